// ===== sv/cfh_pkg.sv =====
// ----------------------------------------------------------------------------
// cfh_pkg: shared types and constants for the compass heading block
// Angle formats, the arctangent table and the per-stage control word.
// ----------------------------------------------------------------------------
package cfh_pkg;

  localparam int AngleWidth = 26;
  localparam int AngleFrac  = 12;
  localparam int TableLen   = 24;
  localparam int DeclWidth  = 13;
  localparam int HeadWidth  = 13;
  localparam int RoundWidth = AngleWidth - AngleFrac;
  localparam int SumWidth   = RoundWidth + 1;
  localparam int GuardBits  = 3;

  localparam logic signed [AngleWidth-1:0] HalfTurnZ  = 26'sd11796480;
  localparam logic signed [AngleWidth-1:0] RoundHalf  = 26'sd2048;
  localparam logic signed [SumWidth-1:0]   FullTurn   = 15'sd5760;
  localparam logic signed [DeclWidth-1:0]  DeclReset  = 13'sd206;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  typedef logic signed [AngleWidth-1:0] angle_t;

  function automatic angle_t atan_step(input int idx);
    angle_t v;
    case (idx)
      0:       v = 26'sd2949120;
      1:       v = 26'sd1740967;
      2:       v = 26'sd919879;
      3:       v = 26'sd466945;
      4:       v = 26'sd234379;
      5:       v = 26'sd117304;
      6:       v = 26'sd58666;
      7:       v = 26'sd29335;
      8:       v = 26'sd14668;
      9:       v = 26'sd7334;
      10:      v = 26'sd3667;
      11:      v = 26'sd1833;
      12:      v = 26'sd917;
      13:      v = 26'sd458;
      14:      v = 26'sd229;
      15:      v = 26'sd115;
      16:      v = 26'sd57;
      17:      v = 26'sd29;
      18:      v = 26'sd14;
      19:      v = 26'sd7;
      20:      v = 26'sd4;
      21:      v = 26'sd2;
      22:      v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/compass_heading_from_field_top.sv =====
// ----------------------------------------------------------------------------
// compass_heading_from_field_top: magnetometer heading by CORDIC
// atan2(Y, X) through a pipelined chain of vectoring cells plus declination.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    start, busy, in_field_x, in_field_y     start & !busy
//  result   out_strobe, out_heading                 out_strobe, one cycle
//  config   cfg_valid, cfg_ready, cfg_declination   cfg_valid & cfg_ready
//
//  One word in every cycle; busy stays low.
//  Registered stages in order: pre-rotation, one per cell, output stage.
//  The cell chain is CORDIC_STEPS long, capped at the table length.
//  Synchronous reset clears stage valids; declination returns to 206.
//  The receiver cannot stall; every result shows for one cycle.
// ----------------------------------------------------------------------------
module compass_heading_from_field_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int FIELD_WIDTH  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [FIELD_WIDTH-1:0]         in_field_x,
  input  logic signed [FIELD_WIDTH-1:0]         in_field_y,
  output logic                                  out_strobe,
  output logic [cfh_pkg::HeadWidth-1:0]         out_heading,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [cfh_pkg::DeclWidth-1:0]  cfg_declination
);

  localparam int NSTEP = (CORDIC_STEPS > cfh_pkg::TableLen) ? cfh_pkg::TableLen : CORDIC_STEPS;
  localparam int DW    = FIELD_WIDTH + cfh_pkg::GuardBits;

  logic signed [cfh_pkg::DeclWidth-1:0] decl_r;
  cfh_pkg::ctl_t                        ctl_s [0:NSTEP];
  logic signed [DW-1:0]                 x_s   [0:NSTEP];
  logic signed [DW-1:0]                 y_s   [0:NSTEP];
  cfh_pkg::angle_t                      z_s   [0:NSTEP];

  cfh_pkg::ctl_t         ctl_r, ctl_nxt;
  logic signed [DW-1:0]  x_r, x_nxt;
  logic signed [DW-1:0]  y_r, y_nxt;
  cfh_pkg::angle_t       z_r, z_nxt;
  logic signed [DW-1:0]  x_ext, y_ext;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= cfh_pkg::DeclReset;
    end else if (cfg_valid && cfg_ready) begin
      decl_r <= cfg_declination;
    end
  end

  // pre-rotate into the right half plane
  always_comb begin
    x_ext        = {{cfh_pkg::GuardBits{in_field_x[FIELD_WIDTH-1]}}, in_field_x};
    y_ext        = {{cfh_pkg::GuardBits{in_field_y[FIELD_WIDTH-1]}}, in_field_y};
    ctl_nxt.vld  = start && !busy;
    ctl_nxt.zero = (in_field_x == '0) && (in_field_y == '0);
    if (in_field_x[FIELD_WIDTH-1]) begin
      x_nxt = -x_ext;
      y_nxt = -y_ext;
      z_nxt = cfh_pkg::HalfTurnZ;
    end else begin
      x_nxt = x_ext;
      y_nxt = y_ext;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_s[0] = ctl_r;
  assign x_s[0]   = x_r;
  assign y_s[0]   = y_r;
  assign z_s[0]   = z_r;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    cfh_cell #(
      .DW   (DW),
      .STEP (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_s[i]),
      .x_in    (x_s[i]),
      .y_in    (y_s[i]),
      .z_in    (z_s[i]),
      .ctl_out (ctl_s[i+1]),
      .x_out   (x_s[i+1]),
      .y_out   (y_s[i+1]),
      .z_out   (z_s[i+1])
    );
  end

  cfh_heading u_heading (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_s[NSTEP]),
    .z_in    (z_s[NSTEP]),
    .decl    (decl_r),
    .strobe  (out_strobe),
    .heading (out_heading)
  );

endmodule

// ===== sv/cfh_cell.sv =====
// ----------------------------------------------------------------------------
// cfh_cell: one vectoring CORDIC step
// Rotates the vector toward the X axis by atan(2^-STEP) and registers it.
// ----------------------------------------------------------------------------
module cfh_cell #(
  parameter int DW   = 27,
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfh_pkg::ctl_t          ctl_in,
  input  logic signed [DW-1:0]   x_in,
  input  logic signed [DW-1:0]   y_in,
  input  cfh_pkg::angle_t        z_in,
  output cfh_pkg::ctl_t          ctl_out,
  output logic signed [DW-1:0]   x_out,
  output logic signed [DW-1:0]   y_out,
  output cfh_pkg::angle_t        z_out
);

  localparam cfh_pkg::angle_t AtanVal = cfh_pkg::atan_step(STEP);

  cfh_pkg::ctl_t         ctl_r;
  logic signed [DW-1:0]  x_r, x_nxt;
  logic signed [DW-1:0]  y_r, y_nxt;
  cfh_pkg::angle_t       z_r, z_nxt;
  logic signed [DW-1:0]  xs, ys;

  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (!y_in[DW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + AtanVal;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - AtanVal;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

// ===== sv/cfh_heading.sv =====
// ----------------------------------------------------------------------------
// cfh_heading: heading rounding, declination and wrap
// Rounds the angle to sixteenths, adds declination, wraps into 0..5759.
// ----------------------------------------------------------------------------
module cfh_heading (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  cfh_pkg::ctl_t                           ctl_in,
  input  cfh_pkg::angle_t                         z_in,
  input  logic signed [cfh_pkg::DeclWidth-1:0]    decl,
  output logic                                    strobe,
  output logic [cfh_pkg::HeadWidth-1:0]           heading
);

  logic                                       strobe_r;
  logic [cfh_pkg::HeadWidth-1:0]              heading_r, heading_nxt;
  cfh_pkg::angle_t                            z_sel, z_rnd;
  logic signed [cfh_pkg::RoundWidth-1:0]      rnd;
  logic signed [cfh_pkg::SumWidth-1:0]        sum, wrapped;

  always_comb begin
    z_sel = ctl_in.zero ? '0 : z_in;
    z_rnd = (z_sel + cfh_pkg::RoundHalf) >>> cfh_pkg::AngleFrac;
    rnd   = z_rnd[cfh_pkg::RoundWidth-1:0];
    sum   = cfh_pkg::SumWidth'(rnd) + cfh_pkg::SumWidth'(decl);
    if (sum[cfh_pkg::SumWidth-1]) begin
      wrapped = sum + cfh_pkg::FullTurn;
    end else if (sum >= cfh_pkg::FullTurn) begin
      wrapped = sum - cfh_pkg::FullTurn;
    end else begin
      wrapped = sum;
    end
    heading_nxt = wrapped[cfh_pkg::HeadWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    heading_r <= heading_nxt;
  end

  assign strobe  = strobe_r;
  assign heading = heading_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for compass_heading_from_field_top
// Drives magnetometer samples with random start gaps and predicts each heading
// with a bit-exact CORDIC vectoring model. It checks every strobed result in
// order. It steps the declination register through its extremes between
// phases.
// ----------------------------------------------------------------------------

class heading_scoreboard;
  localparam int     AngleFrac = 12;
  localparam int     LutLen    = 24;
  localparam longint HalfTurn  = 2880;
  localparam longint FullTurn  = 5760;

  longint      declination;
  longint      atan_lut[LutLen];
  logic [12:0] heading_q[$];
  int          errors;
  int          steps;

  function new(int cordic_steps);
    declination = cfh_pkg::DeclReset;
    steps       = (cordic_steps > LutLen) ? LutLen : cordic_steps;
    errors      = 0;
    atan_lut    = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                    14668, 7334, 3667, 1833, 917, 458, 229, 115,
                    57, 29, 14, 7, 4, 2, 1, 0};
  endfunction

  function logic [12:0] predict_heading(longint x, longint y);
    longint xs, ys, z, h, r;
    z = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HalfTurn <<< AngleFrac;
      end
      for (int i = 0; i < steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_lut[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_lut[i];
        end
      end
    end
    h = ((z + (64'sd1 <<< (AngleFrac - 1))) >>> AngleFrac) + declination;
    r = h % FullTurn;
    if (r < 0) r = r + FullTurn;
    return r[12:0];
  endfunction

  function void note_sample(longint x, longint y);
    heading_q.push_back(predict_heading(x, y));
  endfunction

  function void check_heading(logic [12:0] actual);
    logic [12:0] want;
    if (heading_q.size() == 0) begin
      $error("heading: no word expected, actual %0d", actual);
      errors++;
    end else begin
      want = heading_q.pop_front();
      if (actual !== want) begin
        $error("heading: expected %0d, actual %0d", want, actual);
        errors++;
      end
    end
  endfunction
endclass

module tb;
  localparam int CordicSteps = 16;
  localparam int FieldWidth  = 24;
  localparam int Latency     = CordicSteps + 2;
  localparam int IdleLimit   = 2000;
  localparam int PhaseItems  = 160;
  localparam logic signed [FieldWidth-1:0] FieldMin = {1'b1, {(FieldWidth-1){1'b0}}};
  localparam logic signed [FieldWidth-1:0] FieldMax = {1'b0, {(FieldWidth-1){1'b1}}};

  logic                                 clk             = 1'b0;
  logic                                 rst_n           = 1'b0;
  logic                                 start           = 1'b0;
  logic signed [FieldWidth-1:0]         in_field_x      = '0;
  logic signed [FieldWidth-1:0]         in_field_y      = '0;
  logic                                 cfg_valid       = 1'b0;
  logic signed [cfh_pkg::DeclWidth-1:0] cfg_declination = cfh_pkg::DeclReset;
  logic                                 busy;
  logic                                 out_strobe;
  logic [cfh_pkg::HeadWidth-1:0]        out_heading;
  logic                                 cfg_ready;
  int                                   idle_cycles     = 0;

  heading_scoreboard sb;

  compass_heading_from_field_top #(
    .CORDIC_STEPS (CordicSteps),
    .FIELD_WIDTH  (FieldWidth)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_field_x      (in_field_x),
    .in_field_y      (in_field_y),
    .out_strobe      (out_strobe),
    .out_heading     (out_heading),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_declination (cfg_declination)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_sample(in_field_x, in_field_y);
      if (out_strobe) sb.check_heading(out_heading);
      if (cfg_valid && cfg_ready) sb.declination = cfg_declination;
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [FieldWidth-1:0] rand_field();
    logic signed [FieldWidth-1:0] v;
    v = FieldWidth'($urandom);
    case ($urandom_range(0, 9))
      5, 6: begin
        v = FieldWidth'(signed'($urandom_range(0, 128)) - 64);
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       v = FieldMin;
          1:       v = FieldMax;
          2:       v = '1;
          3:       v = FieldWidth'(1);
          default: v = '0;
        endcase
      end
      8:       v = v >>> $urandom_range(0, FieldWidth - 1);
      9:       v = '0;
      default: ;
    endcase
    return v;
  endfunction

  // hold start high across back-to-back words; drop it only for a gap
  task automatic send_sample(input logic signed [FieldWidth-1:0] x,
                             input logic signed [FieldWidth-1:0] y, input int gap);
    start      <= 1'b1;
    in_field_x <= x;
    in_field_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.heading_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_declination(input logic signed [cfh_pkg::DeclWidth-1:0] d);
    drain();
    cfg_valid       <= 1'b1;
    cfg_declination <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase();
    for (int i = 0; i < PhaseItems; i++)
      send_sample(rand_field(), rand_field(), pick_gap(i >= 100 && i < 140));
  endtask

  initial begin
    logic signed [FieldWidth-1:0]         dir_x [20];
    logic signed [FieldWidth-1:0]         dir_y [20];
    logic signed [cfh_pkg::DeclWidth-1:0] decl_plan [7];
    sb = new(CordicSteps);
    // zero field, axes, diagonals, extremes, both sides of the 0 and 180 wrap
    dir_x = '{0, 1, 0, -1, 0, 1, -1, 1, -1, FieldMax,
              FieldMin, 0, 0, FieldMax, FieldMin, FieldMin, FieldMax, FieldMin, -1000, 1000};
    dir_y = '{0, 0, 1, 0, -1, 1, -1, -1, 1, 0,
              0, FieldMax, FieldMin, FieldMax, FieldMin, FieldMax, FieldMin, -1, 1, -1};
    decl_plan = '{-13'sd4096, 13'sd4095, -13'sd2880, 13'sd2879, 13'sd0, -13'sd1, 13'sd0};
    decl_plan[6] = cfh_pkg::DeclWidth'($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 20; i++) send_sample(dir_x[i], dir_y[i], pick_gap(1'b0));
    random_phase();
    for (int p = 0; p < 7; p++) begin
      write_declination(decl_plan[p]);
      if (p == 0)
        for (int i = 0; i < 20; i++) send_sample(dir_x[i], dir_y[i], pick_gap(1'b0));
      random_phase();
    end
    drain();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/cfh_pkg.sv
sv/cfh_cell.sv
sv/cfh_heading.sv
sv/compass_heading_from_field_top.sv
tb/tb.sv
